// ----- sv/pid_position_drive_controller_assert.svh -----
// assertion macros for the drive controller, used by the step sequencer
`ifndef PID_POSITION_DRIVE_CONTROLLER_ASSERT_SVH
`define PID_POSITION_DRIVE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// concurrent assertion on a named clock and active-low reset
`define PDC_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error("pdc assertion failed");
// same, on the block clock and reset
`define PDC_ASSERT(lbl, prop) `PDC_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define PDC_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop)
`define PDC_ASSERT(lbl, prop)
`endif

`endif

// ----- sv/pdc_pkg.sv -----
`default_nettype none

package pdc_pkg;

	// field and internal widths
	localparam int PosW     = 24;
	localparam int GainW    = 24;
	localparam int ZoneW    = 16;
	localparam int ClampW   = 24;
	localparam int PctW     = 7;
	localparam int DistW    = 24;
	localparam int ErrW     = 22;
	localparam int DeW      = 23;
	localparam int IntW     = 32;
	localparam int MulAW    = 25;
	localparam int MulBW    = 32;
	localparam int ProdW    = MulAW + MulBW;
	localparam int AccW     = 58;
	localparam int ClpW     = 24;
	localparam int PowW     = 8;
	localparam int FracBits = 16;
	localparam int ScaledW  = 35;
	localparam int RemW     = 14;
	localparam int CfgDataW = 24;
	localparam int CfgAddrW = 3;

	// distance to ticks: floor(dist * 1125 / 6908)
	localparam logic [10:0] TickNum = 11'd1125;
	localparam logic [12:0] TickDen = 13'd6908;
	localparam int RecipShift = 24;
	localparam logic [63:0] RecipFull = (64'd1 << RecipShift) * 64'd1125 / 64'd6908;
	localparam logic [ErrW-1:0] RecipM = RecipFull[ErrW-1:0];

	// distance bands in ticks
	localparam logic [ErrW-1:0] DeadbandTicks = 22'd25;
	localparam logic [ErrW-1:0] FarTicks      = 22'd800;
	localparam logic [ErrW-1:0] BandHigh      = 22'd500;
	localparam logic [ErrW-1:0] BandMid       = 22'd90;
	localparam logic [ErrW-1:0] BandLow       = 22'd50;

	// fixed band powers
	localparam logic signed [PowW-1:0] PowerFarBand   = 8'sd30;
	localparam logic signed [PowW-1:0] PowerMidBand   = 8'sd10;
	localparam logic signed [PowW-1:0] PowerNearBand  = 8'sd5;
	localparam logic signed [PowW-1:0] PowerCloseBand = 8'sd3;
	localparam logic [PctW-1:0] PowerCeiling = 7'd100;

	localparam logic signed [IntW-1:0] IntMax = 32'sh7fff_ffff;

	// register reset values
	localparam logic signed [PosW-1:0] TargetReset = 24'sd0;
	localparam logic [GainW-1:0]  KpReset    = 24'd11141;
	localparam logic [GainW-1:0]  KiReset    = 24'd3932;
	localparam logic [GainW-1:0]  KdReset    = 24'd655;
	localparam logic [ZoneW-1:0]  ZoneReset  = 16'd30;
	localparam logic [ClampW-1:0] ClampReset = 24'd250;
	localparam logic [PctW-1:0]   MaxPowReset = 7'd60;

	// register indexes
	typedef enum logic [CfgAddrW-1:0] {
		REG_TARGET    = 3'd0,
		REG_KP        = 3'd1,
		REG_KI        = 3'd2,
		REG_KD        = 3'd3,
		REG_ZONE      = 3'd4,
		REG_CLAMP     = 3'd5,
		REG_MAX_POWER = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [PosW-1:0] target_position;
		logic [GainW-1:0]       kp_gain;
		logic [GainW-1:0]       ki_gain;
		logic [GainW-1:0]       kd_gain;
		logic [ZoneW-1:0]       integral_zone;
		logic [ClampW-1:0]      integral_clamp;
		logic [PctW-1:0]        max_power_percent;
	} cfg_t;

	// step commands from the controller
	typedef struct packed {
		logic load_in;
		logic calc_dist;
		logic recip;
		logic corr;
		logic calc_err;
		logic int_acc;
		logic err_upd;
		logic int_clamp;
		logic mul_i;
		logic mul_d;
		logic acc_last;
		logic clamp;
		logic load_out;
	} pdc_cmd_t;

	typedef struct packed {
		logic deadband;
	} pdc_status_t;

endpackage

`default_nettype wire

// ----- sv/pdc_cfg_regs.sv -----
`default_nettype none

module pdc_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [pdc_pkg::CfgAddrW-1:0]  cfg_addr,
	input  wire logic [pdc_pkg::CfgDataW-1:0]  cfg_wdata,
	output pdc_pkg::cfg_t                      cfg
);

	pdc_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_position   <= pdc_pkg::TargetReset;
			cfg_q.kp_gain           <= pdc_pkg::KpReset;
			cfg_q.ki_gain           <= pdc_pkg::KiReset;
			cfg_q.kd_gain           <= pdc_pkg::KdReset;
			cfg_q.integral_zone     <= pdc_pkg::ZoneReset;
			cfg_q.integral_clamp    <= pdc_pkg::ClampReset;
			cfg_q.max_power_percent <= pdc_pkg::MaxPowReset;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				pdc_pkg::REG_TARGET:    cfg_q.target_position <= cfg_wdata;
				pdc_pkg::REG_KP:        cfg_q.kp_gain <= cfg_wdata;
				pdc_pkg::REG_KI:        cfg_q.ki_gain <= cfg_wdata;
				pdc_pkg::REG_KD:        cfg_q.kd_gain <= cfg_wdata;
				pdc_pkg::REG_ZONE:      cfg_q.integral_zone <= cfg_wdata[pdc_pkg::ZoneW-1:0];
				pdc_pkg::REG_CLAMP:     cfg_q.integral_clamp <= cfg_wdata;
				pdc_pkg::REG_MAX_POWER: cfg_q.max_power_percent <= cfg_wdata[pdc_pkg::PctW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- sv/pdc_ctrl.sv -----
`default_nettype none

`include "pid_position_drive_controller_assert.svh"

module pdc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire pdc_pkg::pdc_status_t status,
	output pdc_pkg::pdc_cmd_t  cmd
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_DIST  = 12'b0000_0000_0010,
		ST_RECIP = 12'b0000_0000_0100,
		ST_CORR  = 12'b0000_0000_1000,
		ST_ERR   = 12'b0000_0001_0000,
		ST_INT1  = 12'b0000_0010_0000,
		ST_INT2  = 12'b0000_0100_0000,
		ST_MULI  = 12'b0000_1000_0000,
		ST_MULD  = 12'b0001_0000_0000,
		ST_ACC   = 12'b0010_0000_0000,
		ST_CLAMP = 12'b0100_0000_0000,
		ST_FIN   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// step sequencing
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
				if (s_tvalid) state_d = ST_DIST;
			end
			ST_DIST: begin
				cmd.calc_dist = 1'b1;
				state_d = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.recip = 1'b1;
				state_d = ST_CORR;
			end
			ST_CORR: begin
				cmd.corr = 1'b1;
				state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.calc_err = 1'b1;
				state_d = ST_INT1;
			end
			ST_INT1: begin
				cmd.err_upd = 1'b1;
				cmd.int_acc = !status.deadband;
				state_d = status.deadband ? ST_FIN : ST_INT2;
			end
			ST_INT2: begin
				cmd.int_clamp = 1'b1;
				state_d = ST_MULI;
			end
			ST_MULI: begin
				cmd.mul_i = 1'b1;
				state_d = ST_MULD;
			end
			ST_MULD: begin
				cmd.mul_d = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_last = 1'b1;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.load_out = !out_valid_q || m_tready;
				if (!out_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	// accepted request starts the distance step
	`PDC_ASSERT(a_accept_starts, (s_tvalid && s_tready) |=> (state_q == ST_DIST))
	// deadband skips the gain products
	`PDC_ASSERT(a_deadband_skip, (state_q == ST_INT1 && status.deadband) |=> (state_q == ST_FIN))
	// a pending result holds the last step
	`PDC_ASSERT(a_fin_stall, (state_q == ST_FIN && m_tvalid && !m_tready) |=> (state_q == ST_FIN))

endmodule

`default_nettype wire

// ----- sv/pdc_dp.sv -----
`default_nettype none

module pdc_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [pdc_pkg::PosW-1:0]   measured_position,
	input  wire pdc_pkg::cfg_t              cfg,
	input  wire pdc_pkg::pdc_cmd_t          cmd,
	output pdc_pkg::pdc_status_t            status,
	output logic [pdc_pkg::PowW-1:0]        drive_power,
	output logic                            in_deadband
);

	logic signed [pdc_pkg::PosW-1:0]    pos_q;
	logic [pdc_pkg::DistW-1:0]          dist_q;
	logic [pdc_pkg::ScaledW-1:0]        scaled_q;
	logic signed [pdc_pkg::ProdW-1:0]   prod_s1;
	logic [pdc_pkg::ErrW-1:0]           q0_q;
	logic [pdc_pkg::RemW-1:0]           rem_q;
	logic [pdc_pkg::ErrW-1:0]           err_q;
	logic [pdc_pkg::ErrW-1:0]           last_err_q;
	logic signed [pdc_pkg::DeW-1:0]     de_q;
	logic signed [pdc_pkg::IntW-1:0]    integ_q;
	logic signed [pdc_pkg::AccW-1:0]    acc_q;
	logic signed [pdc_pkg::ClpW-1:0]    clamped_q;
	logic signed [pdc_pkg::PowW-1:0]    power_q;
	logic                               deadband_q;

	// distance to target
	logic signed [pdc_pkg::PosW:0] diff, neg_diff;
	logic [pdc_pkg::DistW-1:0]     dist_abs;

	assign diff     = {pos_q[pdc_pkg::PosW-1], pos_q}
		- {cfg.target_position[pdc_pkg::PosW-1], cfg.target_position};
	assign neg_diff = -diff;
	assign dist_abs = diff[pdc_pkg::PosW] ? neg_diff[pdc_pkg::DistW-1:0]
		: diff[pdc_pkg::DistW-1:0];

	// shared multiplier operand select
	logic signed [pdc_pkg::MulAW-1:0] mul_a;
	logic signed [pdc_pkg::MulBW-1:0] mul_b;
	logic signed [pdc_pkg::ProdW-1:0] mul_p;
	logic                             mul_en;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.recip) begin
			mul_a = {3'b000, pdc_pkg::RecipM};
			mul_b = {8'h00, dist_q};
		end else if (cmd.int_clamp) begin
			mul_a = {1'b0, cfg.kp_gain};
			mul_b = {10'b0, err_q};
		end else if (cmd.mul_i) begin
			mul_a = {1'b0, cfg.ki_gain};
			mul_b = integ_q;
		end else if (cmd.mul_d) begin
			mul_a = {1'b0, cfg.kd_gain};
			mul_b = {{9{de_q[pdc_pkg::DeW-1]}}, de_q};
		end
	end

	assign mul_p  = mul_a * mul_b;
	assign mul_en = cmd.recip | cmd.int_clamp | cmd.mul_i | cmd.mul_d;

	// reciprocal estimate and its remainder
	logic [pdc_pkg::ErrW-1:0]    q0;
	logic [pdc_pkg::ScaledW-1:0] q0_scaled, rem_full;

	assign q0        = prod_s1[pdc_pkg::RecipShift +: pdc_pkg::ErrW];
	assign q0_scaled = pdc_pkg::ScaledW'(q0) * pdc_pkg::ScaledW'(pdc_pkg::TickDen);
	assign rem_full  = scaled_q - q0_scaled;

	// integral accumulate with saturation, cleared outside the zone
	logic [pdc_pkg::IntW:0]          int_sum;
	logic                            int_ovf;
	logic signed [pdc_pkg::IntW-1:0] int_next;
	logic                            in_zone;

	assign int_sum  = {integ_q[pdc_pkg::IntW-1], integ_q} + {11'b0, err_q};
	assign int_ovf  = !int_sum[pdc_pkg::IntW] && int_sum[pdc_pkg::IntW-1];
	assign in_zone  = err_q < pdc_pkg::ErrW'(cfg.integral_zone);
	assign int_next = !in_zone ? '0
		: (int_ovf ? pdc_pkg::IntMax : int_sum[pdc_pkg::IntW-1:0]);

	// integral clamp bounds
	logic signed [pdc_pkg::IntW-1:0] clamp_pos, clamp_neg;

	assign clamp_pos = {8'h00, cfg.integral_clamp};
	assign clamp_neg = -clamp_pos;

	// output limit
	logic [pdc_pkg::PctW-1:0]        lim_pct;
	logic signed [pdc_pkg::AccW-1:0] lim_pos, lim_neg;

	assign lim_pct = (cfg.max_power_percent > pdc_pkg::PowerCeiling) ? pdc_pkg::PowerCeiling
		: cfg.max_power_percent;
	assign lim_pos = {35'b0, lim_pct, 16'h0000};
	assign lim_neg = -lim_pos;

	// power bands
	logic                            clp_neg;
	logic signed [pdc_pkg::ClpW-1:0] clp_negated, clp_mag;
	logic [pdc_pkg::PctW-1:0]        whole;
	logic signed [pdc_pkg::PowW-1:0] far_pow, power_next;

	assign clp_neg     = clamped_q[pdc_pkg::ClpW-1];
	assign clp_negated = -clamped_q;
	assign clp_mag     = clp_neg ? clp_negated : clamped_q;
	assign whole       = clp_mag[pdc_pkg::FracBits +: pdc_pkg::PctW];
	assign far_pow     = clp_neg ? -$signed({1'b0, whole}) : $signed({1'b0, whole});

	always_comb begin
		if (err_q >= pdc_pkg::FarTicks) begin
			power_next = far_pow;
		end else if (err_q > pdc_pkg::BandHigh) begin
			power_next = clp_neg ? -pdc_pkg::PowerFarBand : pdc_pkg::PowerFarBand;
		end else if (err_q > pdc_pkg::BandMid) begin
			power_next = clp_neg ? -pdc_pkg::PowerMidBand : pdc_pkg::PowerMidBand;
		end else if (err_q > pdc_pkg::BandLow) begin
			power_next = clp_neg ? '0 : pdc_pkg::PowerNearBand;
		end else begin
			power_next = clp_neg ? '0 : pdc_pkg::PowerCloseBand;
		end
	end

	assign status.deadband = err_q <= pdc_pkg::DeadbandTicks;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) pos_q <= measured_position;
		if (cmd.calc_dist) dist_q <= dist_abs;
		if (cmd.recip) scaled_q <= pdc_pkg::ScaledW'(dist_q) * pdc_pkg::ScaledW'(pdc_pkg::TickNum);
		if (mul_en) prod_s1 <= mul_p;
		if (cmd.corr) begin
			q0_q  <= q0;
			rem_q <= rem_full[pdc_pkg::RemW-1:0];
		end
		if (cmd.calc_err) begin
			err_q <= q0_q + pdc_pkg::ErrW'(rem_q >= pdc_pkg::RemW'(pdc_pkg::TickDen));
		end
		if (cmd.err_upd) de_q <= $signed({1'b0, err_q}) - $signed({1'b0, last_err_q});
		if (cmd.mul_i) begin
			acc_q <= {prod_s1[pdc_pkg::ProdW-1], prod_s1};
		end else if (cmd.mul_d || cmd.acc_last) begin
			acc_q <= acc_q + {prod_s1[pdc_pkg::ProdW-1], prod_s1};
		end
		if (cmd.clamp) begin
			if (acc_q > lim_pos) clamped_q <= lim_pos[pdc_pkg::ClpW-1:0];
			else if (acc_q < lim_neg) clamped_q <= lim_neg[pdc_pkg::ClpW-1:0];
			else clamped_q <= acc_q[pdc_pkg::ClpW-1:0];
		end
		if (cmd.load_out) begin
			deadband_q <= status.deadband;
			power_q    <= status.deadband ? '0 : power_next;
		end
	end

	// controller state carried between requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			integ_q    <= '0;
		end else begin
			if (cmd.err_upd) last_err_q <= err_q;
			if (cmd.int_acc) begin
				integ_q <= int_next;
			end else if (cmd.int_clamp && cfg.ki_gain != '0) begin
				if (integ_q > clamp_pos) integ_q <= clamp_pos;
				else if (integ_q < clamp_neg) integ_q <= clamp_neg;
			end
		end
	end

	assign drive_power = power_q;
	assign in_deadband = deadband_q;

endmodule

`default_nettype wire

// ----- sv/pid_position_drive_controller.sv -----
`default_nettype none

// Position drive controller: each request on the s_ side is one measured position; one
// result per request leaves on the m_ side with a drive power percent and a deadband flag.
// The next request is taken only once the block is back in idle, so requests do not
// overlap; a request in the deadband skips the gain products. The pace is set by one
// shared 25x32 multiplier, used in turn for the reciprocal tick conversion and for
// the P, I and D products, and by the sequence of integral, clamp and band steps
// around it. A finished result waits in the output register while the next request
// is taken. Configuration is to be written through the plain write port while the block
// is idle, which the block itself does not enforce; no reset sweep is needed.
module pid_position_drive_controller (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// tdata: measured_position [23:0]
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [23:0]                  s_tdata,
	// tdata: drive_power [7:0]
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [7:0]                        m_tdata,
	// tuser: in_deadband [0]
	output logic [0:0]                        m_tuser,
	input  wire logic                         cfg_wr_en,
	input  wire logic [pdc_pkg::CfgAddrW-1:0] cfg_addr,
	input  wire logic [pdc_pkg::CfgDataW-1:0] cfg_wdata
);

	pdc_pkg::cfg_t        cfg;
	pdc_pkg::pdc_cmd_t    cmd;
	pdc_pkg::pdc_status_t status;
	logic                 in_deadband;

	// configuration registers
	pdc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// step sequencer
	pdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic
	pdc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.measured_position (s_tdata),
		.cfg               (cfg),
		.cmd               (cmd),
		.status            (status),
		.drive_power       (m_tdata),
		.in_deadband       (in_deadband)
	);

	assign m_tuser = in_deadband;

endmodule

`default_nettype wire

// ----- verif/tb_pid_position_drive_controller.sv -----
`timescale 1ns / 100ps

module tb_pid_position_drive_controller;

	localparam int ClkPeriod    = 10;
	localparam int ResetCycles  = 12;
	localparam int SettleCycles = 20;
	localparam int HoldCycles   = 400;
	localparam int RunLimitNs   = 5_000_000;

	// tick bands and powers of the drive law
	localparam longint DeadTicks  = 25;
	localparam longint FarTicks   = 800;
	localparam longint HighTicks  = 500;
	localparam longint MidTicks   = 90;
	localparam longint LowTicks   = 50;
	localparam int     FarPower   = 30;
	localparam int     MidPower   = 10;
	localparam int     NearPower  = 5;
	localparam int     ClosePower = 3;
	localparam longint PctCeiling = 100;
	localparam longint IntegMax   = 64'sd2147483647;

	typedef struct {
		logic signed [7:0] power;
		logic              deadband;
	} drive_result_t;

	// tracks controller state and the drive results still owed by the block
	class drive_scoreboard;
		logic signed [23:0] target;
		logic [23:0]        kp;
		logic [23:0]        ki;
		logic [23:0]        kd;
		logic [15:0]        zone;
		logic [23:0]        clamp;
		logic [6:0]         max_pct;
		logic [23:0]        last_ticks;
		longint             integ;
		drive_result_t      expected_drives[$];
		int                 mismatches;

		function new();
			target     = pdc_pkg::TargetReset;
			kp         = pdc_pkg::KpReset;
			ki         = pdc_pkg::KiReset;
			kd         = pdc_pkg::KdReset;
			zone       = pdc_pkg::ZoneReset;
			clamp      = pdc_pkg::ClampReset;
			max_pct    = pdc_pkg::MaxPowReset;
			last_ticks = '0;
			integ      = 0;
			mismatches = 0;
		endfunction

		function void write_reg(pdc_pkg::cfg_reg_t idx, logic [23:0] val);
			case (idx)
				pdc_pkg::REG_TARGET:    target  = val;
				pdc_pkg::REG_KP:        kp      = val;
				pdc_pkg::REG_KI:        ki      = val;
				pdc_pkg::REG_KD:        kd      = val;
				pdc_pkg::REG_ZONE:      zone    = val[15:0];
				pdc_pkg::REG_CLAMP:     clamp   = val;
				pdc_pkg::REG_MAX_POWER: max_pct = val[6:0];
				default: ;
			endcase
		endfunction

		// work out the drive result for one accepted position
		function void note_position(logic [23:0] pos);
			longint        diff;
			longint        ticks;
			longint        prev;
			longint        pid;
			longint        lim;
			longint        lim_pid;
			int            pwr;
			drive_result_t res;
			diff = longint'($signed(pos)) - longint'(target);
			if (diff < 0)
				diff = -diff;
			ticks = diff * 1125 / 6908;
			prev = longint'(last_ticks);
			last_ticks = ticks[23:0];
			if (ticks <= DeadTicks) begin
				res.power = '0;
				res.deadband = 1'b1;
				expected_drives.push_back(res);
				return;
			end
			// integral only grows inside the zone
			if (ticks < longint'(zone)) begin
				integ += ticks;
				if (integ > IntegMax)
					integ = IntegMax;
			end else begin
				integ = 0;
			end
			if (ki != 0) begin
				if (integ > longint'(clamp))
					integ = longint'(clamp);
				else if (integ < -longint'(clamp))
					integ = -longint'(clamp);
			end
			pid = longint'(kp) * ticks + longint'(ki) * integ
				+ longint'(kd) * (ticks - prev);
			lim = (longint'(max_pct) > PctCeiling ? PctCeiling : longint'(max_pct)) * 65536;
			lim_pid = pid;
			if (lim_pid > lim)
				lim_pid = lim;
			else if (lim_pid < -lim)
				lim_pid = -lim;
			// fixed bands override the pid output near the target
			if (ticks >= FarTicks)
				pwr = int'(lim_pid / 65536);
			else if (ticks > HighTicks)
				pwr = lim_pid < 0 ? -FarPower : FarPower;
			else if (ticks > MidTicks)
				pwr = lim_pid < 0 ? -MidPower : MidPower;
			else if (ticks > LowTicks)
				pwr = lim_pid < 0 ? 0 : NearPower;
			else
				pwr = lim_pid < 0 ? 0 : ClosePower;
			res.power = pwr[7:0];
			res.deadband = 1'b0;
			expected_drives.push_back(res);
		endfunction

		function void check_drive(logic [7:0] power, logic deadband);
			drive_result_t exp_res;
			if (expected_drives.size() == 0) begin
				$display("%0t: unexpected result power=%0d deadband=%0b", $time,
					$signed(power), deadband);
				mismatches++;
				return;
			end
			exp_res = expected_drives.pop_front();
			if (power !== exp_res.power) begin
				$display("%0t: drive_power mismatch expected=%0d actual=%0d", $time,
					exp_res.power, $signed(power));
				mismatches++;
			end
			if (deadband !== exp_res.deadband) begin
				$display("%0t: in_deadband mismatch expected=%0b actual=%0b", $time,
					exp_res.deadband, deadband);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_wr_en;
	logic [pdc_pkg::CfgAddrW-1:0] cfg_addr;
	logic [pdc_pkg::CfgDataW-1:0] cfg_wdata;

	drive_scoreboard sb = new();
	bit hold_request = 1'b0;

	pid_position_drive_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	initial begin
		#RunLimitNs;
		$display("[pid_position_drive_controller] ERROR");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// smallest distance in 1/256 inch that reaches the given tick count
	function automatic longint dist_for_ticks(longint ticks);
		return (ticks * 6908 + 1124) / 1125;
	endfunction

	function automatic logic [23:0] pos_at_ticks(longint ticks, bit negative, int jitter);
		longint span;
		longint pos;
		span = dist_for_ticks(ticks) + longint'(jitter);
		pos = negative ? longint'(sb.target) - span : longint'(sb.target) + span;
		if (pos > 8388607 || pos < -8388608)
			pos = negative ? longint'(sb.target) + span : longint'(sb.target) - span;
		if (pos > 8388607)
			pos = 8388607;
		else if (pos < -8388608)
			pos = -8388608;
		return pos[23:0];
	endfunction

	// offer one position request after a random gap
	task automatic send_position(input logic [23:0] pos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= pos;
		do @(posedge clk); while (!s_tready);
		sb.note_position(pos);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input pdc_pkg::cfg_reg_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic write_settings(input logic [23:0] target, input logic [23:0] kp,
			input logic [23:0] ki, input logic [23:0] kd, input logic [15:0] zone,
			input logic [23:0] clamp, input logic [6:0] max_pct);
		write_reg(pdc_pkg::REG_TARGET, target);
		write_reg(pdc_pkg::REG_KP, kp);
		write_reg(pdc_pkg::REG_KI, ki);
		write_reg(pdc_pkg::REG_KD, kd);
		write_reg(pdc_pkg::REG_ZONE, {8'h00, zone});
		write_reg(pdc_pkg::REG_CLAMP, clamp);
		write_reg(pdc_pkg::REG_MAX_POWER, {17'h0, max_pct});
	endtask

	function automatic logic [23:0] pick_gain();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 24'($urandom_range(0, 60000));
		else if (roll < 8)
			return 24'($urandom_range(0, 400));
		return 24'($urandom_range(0, 24'hffffff));
	endfunction

	task automatic random_settings();
		logic [15:0] zone;
		logic [23:0] clamp;
		logic [6:0]  max_pct;
		zone = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
			: 16'($urandom_range(0, 1000));
		clamp = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 24'hffffff))
			: 24'($urandom_range(0, 5000));
		max_pct = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
			: 7'($urandom_range(0, 100));
		write_settings(24'($urandom_range(0, 24'hffffff)), pick_gain(), pick_gain(),
			pick_gain(), zone, clamp, max_pct);
	endtask

	// runs of nearby errors build up integral and derivative history
	task automatic random_positions(input int count);
		int     sent;
		int     run_len;
		int     band;
		longint base;
		longint ticks;
		sent = 0;
		while (sent < count) begin
			run_len = $urandom_range(1, 8);
			band = $urandom_range(0, 9);
			case (band)
				0: base = $urandom_range(0, 25);
				1: base = $urandom_range(26, 50);
				2: base = $urandom_range(51, 90);
				3: base = $urandom_range(91, 500);
				4: base = $urandom_range(501, 799);
				5: base = $urandom_range(800, 5000);
				6: base = $urandom_range(26, 40);
				7: base = $urandom_range(26, longint'(sb.zone) > 27 ? sb.zone : 27);
				default: base = -1;
			endcase
			repeat (run_len) begin
				if (base < 0) begin
					send_position(24'($urandom_range(0, 24'hffffff)));
				end else begin
					ticks = base + $urandom_range(0, 6) - 3;
					if (ticks < 0)
						ticks = 0;
					send_position(pos_at_ticks(ticks, 1'($urandom_range(0, 1)),
						$urandom_range(0, 3)));
				end
				sent++;
			end
		end
	endtask

	// receiver readiness with random gaps and one long hold on request
	initial begin
		int burst;
		int low;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 20);
				m_tready <= 1'b1;
				repeat (burst) @(negedge clk);
				low = pick_gap();
				if (low > 0) begin
					m_tready <= 1'b0;
					repeat (low) @(negedge clk);
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_drive(m_tdata, m_tuser[0]);
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes and band edges at reset settings
		send_position(24'h000000);
		send_position(24'h7fffff);
		send_position(24'h800000);
		send_position(pos_at_ticks(DeadTicks, 1'b0, 0));
		send_position(pos_at_ticks(DeadTicks + 1, 1'b1, 0));
		send_position(pos_at_ticks(27, 1'b0, 0));
		send_position(pos_at_ticks(28, 1'b1, 0));
		send_position(pos_at_ticks(29, 1'b0, 0));
		send_position(pos_at_ticks(LowTicks, 1'b0, 0));
		send_position(pos_at_ticks(LowTicks + 1, 1'b1, 0));
		send_position(pos_at_ticks(MidTicks, 1'b0, 0));
		send_position(pos_at_ticks(MidTicks + 1, 1'b1, 0));
		send_position(pos_at_ticks(HighTicks, 1'b0, 0));
		send_position(pos_at_ticks(HighTicks + 1, 1'b1, 0));
		send_position(pos_at_ticks(FarTicks - 1, 1'b0, 0));
		send_position(pos_at_ticks(FarTicks, 1'b1, 0));
		// sharp drop in error drives the sum negative in each band
		send_position(24'h7fffff);
		send_position(pos_at_ticks(60, 1'b0, 0));
		send_position(24'h800000);
		send_position(pos_at_ticks(40, 1'b1, 0));
		send_position(24'h7fffff);
		send_position(pos_at_ticks(300, 1'b0, 0));
		send_position(24'h800000);
		send_position(pos_at_ticks(600, 1'b1, 0));
		wait_drained();

		// all registers at their upper extremes, power limit at the ceiling
		write_settings(24'h7fffff, 24'hffffff, 24'hffffff, 24'hffffff, 16'hffff,
			24'hffffff, 7'd100);
		random_positions(90);
		wait_drained();

		// all registers at their lower extremes
		write_settings(24'h800000, 24'h0, 24'h0, 24'h0, 16'h0, 24'h0, 7'd0);
		random_positions(60);
		wait_drained();

		// unclamped integral with a wide zone, power limit above the ceiling
		write_settings(24'h001234, 24'd20000, 24'd0, 24'd900, 16'hffff, 24'd100, 7'd127);
		random_positions(80);
		wait_drained();
		// same integral history now seen through a nonzero ki
		write_reg(pdc_pkg::REG_KI, 24'd5000);
		random_positions(40);
		wait_drained();

		// random settings, one phase with the receiver held off
		for (int phase = 0; phase < 6; phase++) begin
			random_settings();
			if (phase == 2)
				hold_request = 1'b1;
			random_positions(90);
			wait_drained();
		end

		if (sb.mismatches == 0)
			$display("[pid_position_drive_controller] OK");
		else
			$display("[pid_position_drive_controller] ERROR");
		$finish;
	end

endmodule

// ----- pid_position_drive_controller.f -----
+incdir+sv
sv/pdc_pkg.sv
sv/pdc_cfg_regs.sv
sv/pdc_ctrl.sv
sv/pdc_dp.sv
sv/pid_position_drive_controller.sv
verif/tb_pid_position_drive_controller.sv
